>>> rtl/mcbq_pkg.sv
// Package for the multi-class bounded queue.
// Holds the default parameters, the field widths and the action and status codes.
// No dependencies.
package mcbq_pkg;

    localparam int P_NUM_CLASSES = 32;
    localparam int P_QUEUE_DEPTH = 8;
    localparam int P_ID_WIDTH    = 16;

    localparam int ACTION_W = 2;
    localparam int CLASS_W  = 5;
    localparam int ITEM_W   = 16;
    localparam int STATUS_W = 2;
    localparam int TAKEN_W  = 16;
    localparam int COUNT_W  = 4;

    localparam logic [ACTION_W-1:0] ACT_ADD_TAIL = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_HEAD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TAKE     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

>>> rtl/mcbq_if.sv
// Request and response channel interfaces of the multi-class bounded queue.
// Valid/ready handshake with payload; depends on mcbq_pkg.
interface mcbq_req_if import mcbq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CLASS_W-1:0]  class_index;
    logic [ITEM_W-1:0]   item_id;

    modport source (output valid, action, class_index, item_id, input ready);
    modport sink   (input valid, action, class_index, item_id, output ready);
endinterface

interface mcbq_rsp_if import mcbq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAKEN_W-1:0]  taken_id;
    logic [COUNT_W-1:0]  queue_count;

    modport source (output valid, status, taken_id, queue_count, input ready);
    modport sink   (input valid, status, taken_id, queue_count, output ready);
endinterface

>>> rtl/mcbq_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module mcbq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/multi_class_bounded_queue.sv
// Multi-class bounded queue: one ring per class with head pointer and count.
// Request channel: action, class_index, item_id. Response channel: status,
// taken_id, queue_count; exactly one response per accepted request.
// Add at tail appends, add at head inserts in front of the head, take pops
// the head. Add to a full class answers full; take from an empty class
// answers empty; neither changes state.
// Per-class head and count live in a metadata RAM (one entry per class, a
// valid bit per entry reads as zero until first written); item ids live in
// an entry RAM of NUM_CLASSES*QUEUE_DEPTH words.
// One request is worked at a time. From acceptance to response valid, an add
// passes metadata RAM read, modify and write back, then the output register;
// a take also passes one entry RAM read before the output register. The next
// request is accepted the cycle after the response is loaded. A response
// waits in the output register while the receiver stalls; the next request
// is still worked, then held in its output state, and no further request is
// taken until the register frees.
// Reset (i_rst_n low, synchronous) empties all classes; no clearing pass.
// Depends on mcbq_pkg, mcbq_if, mcbq_ram.
module multi_class_bounded_queue import mcbq_pkg::*; #(
    parameter int NUM_CLASSES = P_NUM_CLASSES,
    parameter int QUEUE_DEPTH = P_QUEUE_DEPTH,
    parameter int ID_WIDTH    = P_ID_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcbq_req_if.sink    i_req,
    mcbq_rsp_if.source  o_rsp
);

    localparam int CLS_W  = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
    localparam int CMP_W  = $clog2(NUM_CLASSES + 1);
    localparam int CEXT_W = CMP_W > CLASS_W ? CMP_W : CLASS_W;
    localparam int HP_W   = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = (HP_W > CNT_W ? HP_W : CNT_W) + 1;
    localparam int META_W = HP_W + CNT_W;
    localparam int SLOTS  = NUM_CLASSES * QUEUE_DEPTH;
    localparam int AW     = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int IDS_W  = ID_WIDTH < ITEM_W ? ID_WIDTH : ITEM_W;

    typedef enum logic [1:0] {S_IDLE, S_META, S_TAKE, S_OUT} t_state;

    t_state              r_state;
    logic [ACTION_W-1:0] r_action;
    logic                r_cls_ok;
    logic [CLS_W-1:0]    r_cls;
    logic [IDS_W-1:0]    r_id;
    logic [STATUS_W-1:0] r_status;
    logic [TAKEN_W-1:0]  r_taken;
    logic [COUNT_W-1:0]  r_count;
    logic                r_vld [NUM_CLASSES];
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_o_status;
    logic [TAKEN_W-1:0]  r_o_taken;
    logic [COUNT_W-1:0]  r_o_count;

    logic [CEXT_W-1:0]   in_cls_ext;
    logic [CLS_W-1:0]    meta_raddr;
    logic [META_W-1:0]   meta_rdata;
    logic [META_W-1:0]   meta_cur;
    logic [HP_W-1:0]     head;
    logic [CNT_W-1:0]    cnt;
    logic [SUM_W-1:0]    tail_sum;
    logic [HP_W-1:0]     tail_pos;
    logic [HP_W-1:0]     n_head;
    logic [CNT_W-1:0]    n_cnt;
    logic [STATUS_W-1:0] n_status;
    logic [HP_W-1:0]     n_pos;
    logic                n_data_we;
    logic                n_take;
    logic                meta_we;
    logic [AW-1:0]       slot_addr;
    logic [IDS_W-1:0]    data_rdata;

    assign in_cls_ext = CEXT_W'(i_req.class_index);
    assign meta_raddr = in_cls_ext[CLS_W-1:0];

    mcbq_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_CLASSES)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_cls),
        .i_wdata ({n_head, n_cnt}),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    mcbq_ram #(
        .WIDTH (IDS_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (n_data_we),
        .i_waddr (slot_addr),
        .i_wdata (r_id),
        .i_raddr (slot_addr),
        .o_rdata (data_rdata)
    );

    always_comb begin
        meta_cur  = (r_cls_ok && r_vld[r_cls]) ? meta_rdata : '0;
        head      = meta_cur[META_W-1:CNT_W];
        cnt       = meta_cur[CNT_W-1:0];
        tail_sum  = SUM_W'(head) + SUM_W'(cnt);
        tail_pos  = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? HP_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HP_W'(tail_sum);
        n_head    = head;
        n_cnt     = cnt;
        n_status  = ST_DONE;
        n_pos     = head;
        n_data_we = 1'b0;
        n_take    = 1'b0;
        if (r_action == ACT_ADD_TAIL || r_action == ACT_ADD_HEAD) begin
            if (cnt >= CNT_W'(QUEUE_DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                n_cnt     = cnt + CNT_W'(1);
                n_data_we = r_cls_ok;
                if (r_action == ACT_ADD_TAIL) begin
                    n_pos = tail_pos;
                end else begin
                    n_head = (head == '0) ? HP_W'(QUEUE_DEPTH - 1) : head - HP_W'(1);
                    n_pos  = n_head;
                end
            end
        end else if (r_action == ACT_TAKE) begin
            if (cnt == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_cnt  = cnt - CNT_W'(1);
                n_head = (head == HP_W'(QUEUE_DEPTH - 1)) ? '0 : head + HP_W'(1);
                n_take = r_cls_ok;
            end
        end
        if (!r_cls_ok) begin
            n_status = ST_DONE;
        end
        meta_we   = (r_state == S_META) && r_cls_ok;
        n_data_we = n_data_we && (r_state == S_META);
        slot_addr = AW'(r_cls) * AW'(QUEUE_DEPTH) + AW'(n_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (o_rsp.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_action <= i_req.action;
                        r_cls_ok <= in_cls_ext < CEXT_W'(NUM_CLASSES);
                        r_cls    <= in_cls_ext[CLS_W-1:0];
                        r_id     <= i_req.item_id[IDS_W-1:0];
                        r_state  <= S_META;
                    end
                end
                S_META: begin
                    if (meta_we) begin
                        r_vld[r_cls] <= 1'b1;
                    end
                    r_status <= n_status;
                    r_taken  <= '0;
                    r_count  <= r_cls_ok ? COUNT_W'(n_cnt) : '0;
                    r_state  <= n_take ? S_TAKE : S_OUT;
                end
                S_TAKE: begin
                    r_taken <= TAKEN_W'(data_rdata);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_status;
                        r_o_taken  <= r_taken;
                        r_o_count  <= r_count;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.taken_id    = r_o_taken;
    assign o_rsp.queue_count = r_o_count;

endmodule
